/* design/sitd_pkg.sv */
// Shared constants for the signed integer to decimal text converter.
package sitd_pkg;

   localparam int DEFAULT_VALUE_BITS = 32;
   localparam int CHAR_W = 7;
   localparam int DIGIT_W = 4;

   localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

   localparam logic [DIGIT_W-1:0] DIGIT_ADJ_MIN = 4'd5;
   localparam logic [DIGIT_W-1:0] DIGIT_ADJ_ADD = 4'd3;

   // Enough decimal digits for the magnitude of a DEFAULT_VALUE_BITS value.
   localparam int DEFAULT_NUM_DIGITS = (DEFAULT_VALUE_BITS * 77) / 256 + 1;

endpackage

/* design/sitd_dabble.sv */
// One shift-and-add-3 step of the binary to BCD conversion.
module sitd_dabble
   import sitd_pkg::*;
#(
   parameter int NUM_DIGITS = DEFAULT_NUM_DIGITS
) (
   input  logic [NUM_DIGITS*DIGIT_W-1:0] bcd_in,
   input  logic                          bit_in,
   output logic [NUM_DIGITS*DIGIT_W-1:0] bcd_out
);

   localparam int BCD_W = NUM_DIGITS * DIGIT_W;

   logic [BCD_W-1:0] adjusted;

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_in[i*DIGIT_W +: DIGIT_W] >= DIGIT_ADJ_MIN) begin
            adjusted[i*DIGIT_W +: DIGIT_W] = bcd_in[i*DIGIT_W +: DIGIT_W] + DIGIT_ADJ_ADD;
         end else begin
            adjusted[i*DIGIT_W +: DIGIT_W] = bcd_in[i*DIGIT_W +: DIGIT_W];
         end
      end
   end

   assign bcd_out = {adjusted[BCD_W-2:0], bit_in};

endmodule

/* design/signed_int_to_decimal_ascii.sv */
// An accepted value is converted one magnitude bit per cycle by the shift-add-3 loop,
// then leading zero digit slots are skipped, a minus sign is sent for a negative value and
// the digits follow. Characters leave at most one per cycle.
// A new item is taken only once the last character of the previous one has been loaded.
// Reset is synchronous and active high; it clears the sequencer and the output valid.
module signed_int_to_decimal_ascii
   import sitd_pkg::*;
#(
   parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [VALUE_BITS-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [CHAR_W-1:0]            rsp_character,
   output logic                         rsp_last
);

   localparam int NUM_DIGITS = (VALUE_BITS * 77) / 256 + 1;
   localparam int BCD_W = NUM_DIGITS * DIGIT_W;
   localparam int CNT_W = $clog2(VALUE_BITS);
   localparam int REM_W = $clog2(NUM_DIGITS + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CONV = 3'd1;
   localparam logic [2:0] ST_SKIP = 3'd2;
   localparam logic [2:0] ST_SIGN = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [REM_W-1:0]      remain_ff, remain_in;
   logic                  neg_ff, neg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]     char_ff, char_in;
   logic                  last_ff, last_in;

   logic [VALUE_BITS-1:0] raw;
   logic [BCD_W-1:0]      dabble_out;
   logic [DIGIT_W-1:0]    top_digit;
   logic [BCD_W-1:0]      bcd_shifted;
   logic                  out_free;
   logic                  load;

   sitd_dabble #(
      .NUM_DIGITS(NUM_DIGITS)
   ) u_dabble (
      .bcd_in (bcd_ff),
      .bit_in (mag_ff[VALUE_BITS-1]),
      .bcd_out(dabble_out)
   );

   assign raw = req_value;
   assign top_digit = bcd_ff[BCD_W-1 -: DIGIT_W];
   assign bcd_shifted = {bcd_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last = last_ff;

   always_comb begin
      state_in = state_ff;
      mag_in = mag_ff;
      bcd_in = bcd_ff;
      cnt_in = cnt_ff;
      remain_in = remain_ff;
      neg_in = neg_ff;
      load = 1'b0;
      char_in = char_ff;
      last_in = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               neg_in = raw[VALUE_BITS-1];
               mag_in = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
               bcd_in = '0;
               cnt_in = '0;
               remain_in = REM_W'(NUM_DIGITS);
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in = dabble_out;
            mag_in = {mag_ff[VALUE_BITS-2:0], 1'b0};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(VALUE_BITS - 1)) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if ((top_digit == '0) && (remain_ff != REM_W'(1))) begin
               bcd_in = bcd_shifted;
               remain_in = remain_ff - REM_W'(1);
            end else begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               load = 1'b1;
               char_in = CHAR_MINUS;
               last_in = 1'b0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load = 1'b1;
               char_in = CHAR_ZERO + CHAR_W'(top_digit);
               last_in = (remain_ff == REM_W'(1));
               bcd_in = bcd_shifted;
               remain_in = remain_ff - REM_W'(1);
               if (remain_ff == REM_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
      remain_ff <= remain_in;
      neg_ff <= neg_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

`ifndef NO_ASSERTIONS
   a_pending_mid_text: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (state_ff != ST_IDLE))
      else $error("A character other than the last is shown with no item in work.");

   a_emit_has_digits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (remain_ff != '0))
      else $error("Digit emission runs with no digit left.");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_character == CHAR_MINUS)) |-> !rsp_last)
      else $error("A minus sign is marked as the last character.");

   a_accept_starts_conv: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_CONV))
      else $error("An accepted item did not start the conversion.");
`endif

endmodule
